[sv/iq_envelope_peak_clipper_assert.svh]
// ----------------------------------------------------------------------------
// iq_envelope_peak_clipper assertion macros
// shared property forms for the checker of the envelope clipper
// ----------------------------------------------------------------------------
`ifndef IQ_ENVELOPE_PEAK_CLIPPER_ASSERT_SVH
`define IQ_ENVELOPE_PEAK_CLIPPER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define IQEPC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define IQEPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/iqepc_pkg.sv]
// ----------------------------------------------------------------------------
// iqepc_pkg
// types, constants and register indexes of the I/Q envelope peak clipper
// ----------------------------------------------------------------------------
`default_nettype none

package iqepc_pkg;

    localparam int HOLD_DEPTH_DEF   = 4;
    localparam int SAMPLE_DELAY_DEF = 2;

    localparam int SMP_W      = 16;
    localparam int LVL_W      = 15;
    localparam int AMP_W      = 17;
    localparam int SQ_W       = 32;
    localparam int PROD_W     = 31;
    localparam int ITER_N     = 16;
    localparam int ITER_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [LVL_W-1:0] FLOOR_RST  = 15'd6553;
    localparam logic [LVL_W-1:0] TARGET_RST = 15'd23166;

    localparam logic signed [SMP_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SAT_MIN = 16'sh8000;
    localparam logic [SMP_W-1:0]        POS_LIM = 16'd32767;
    localparam logic [SMP_W-1:0]        NEG_LIM = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_MODE    = 2'd0,
        CFG_FLOOR_LEVEL  = 2'd1,
        CFG_TARGET_LEVEL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SMP_W-1:0] in_i;
        logic signed [SMP_W-1:0] in_q;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_i;
        logic signed [SMP_W-1:0] out_q;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic square;
        logic root_init;
        logic root_step;
        logic amp;
        logic peak;
        logic mul;
        logic div_init;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic iter_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[sv/iqepc_ctrl.sv]
// ----------------------------------------------------------------------------
// iqepc_ctrl
// sequencer: steps one sample through square, root, peak, scale and divide
// ----------------------------------------------------------------------------
`default_nettype none

module iqepc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire iqepc_pkg::t_dp_stat i_stat,
    output iqepc_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_SQR   = 10'b00_0000_0010,
        S_RINIT = 10'b00_0000_0100,
        S_ROOT  = 10'b00_0000_1000,
        S_AMP   = 10'b00_0001_0000,
        S_PEAK  = 10'b00_0010_0000,
        S_MUL   = 10'b00_0100_0000,
        S_DINIT = 10'b00_1000_0000,
        S_DIV   = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.square = 1'b1;
                n_state      = S_RINIT;
            end
            S_RINIT: begin
                o_cmd.root_init = 1'b1;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = S_AMP;
                end
            end
            S_AMP: begin
                o_cmd.amp = 1'b1;
                n_state   = S_PEAK;
            end
            S_PEAK: begin
                o_cmd.peak = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // wait here until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[sv/iqepc_dp.sv]
// ----------------------------------------------------------------------------
// iqepc_dp
// datapath: config registers, delay line, bit-pair square root, peak hold,
// gain multiply, two-lane restoring divider and output register
// ----------------------------------------------------------------------------
`default_nettype none

module iqepc_dp #(
    parameter int HOLD_DEPTH   = iqepc_pkg::HOLD_DEPTH_DEF,
    parameter int SAMPLE_DELAY = iqepc_pkg::SAMPLE_DELAY_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [iqepc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [iqepc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire iqepc_pkg::t_in_item                    i_in_data,
    input  wire iqepc_pkg::t_dp_cmd                     i_cmd,
    output iqepc_pkg::t_dp_stat                         o_stat,
    input  wire logic                                   i_out_ready,
    output logic                                        o_out_valid,
    output iqepc_pkg::t_out_item                        o_out_data
);

    localparam int SMP_W  = iqepc_pkg::SMP_W;
    localparam int LVL_W  = iqepc_pkg::LVL_W;
    localparam int AMP_W  = iqepc_pkg::AMP_W;
    localparam int SQ_W   = iqepc_pkg::SQ_W;
    localparam int PROD_W = iqepc_pkg::PROD_W;
    localparam int ITER_W = iqepc_pkg::ITER_W;
    localparam int IDX_W  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int HI_W   = PROD_W - SMP_W;

    // ---------------- configuration registers ----------------
    logic             r_clip_mode;
    logic [LVL_W-1:0] r_floor;
    logic [LVL_W-1:0] r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_mode <= 1'b0;
            r_floor     <= iqepc_pkg::FLOOR_RST;
            r_target    <= iqepc_pkg::TARGET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                iqepc_pkg::CFG_CLIP_MODE:    r_clip_mode <= i_cfg_data[0];
                iqepc_pkg::CFG_FLOOR_LEVEL:  r_floor     <= i_cfg_data[LVL_W-1:0];
                iqepc_pkg::CFG_TARGET_LEVEL: r_target    <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sample capture and delay line ----------------
    logic signed [SMP_W-1:0] r_cur_i, r_cur_q;
    logic signed [SMP_W-1:0] r_dly_i, r_dly_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur_i <= i_in_data.in_i;
            r_cur_q <= i_in_data.in_q;
        end
    end

    generate
        if (SAMPLE_DELAY == 0) begin : g_no_delay
            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_dly_i <= i_in_data.in_i;
                    r_dly_q <= i_in_data.in_q;
                end
            end
        end else begin : g_delay
            logic signed [SMP_W-1:0] r_line_i [0:SAMPLE_DELAY-1];
            logic signed [SMP_W-1:0] r_line_q [0:SAMPLE_DELAY-1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int k = 0; k < SAMPLE_DELAY; k++) begin
                        r_line_i[k] <= '0;
                        r_line_q[k] <= '0;
                    end
                end else if (i_cmd.capture) begin
                    r_line_i[0] <= i_in_data.in_i;
                    r_line_q[0] <= i_in_data.in_q;
                    for (int k = 1; k < SAMPLE_DELAY; k++) begin
                        r_line_i[k] <= r_line_i[k-1];
                        r_line_q[k] <= r_line_q[k-1];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_dly_i <= r_line_i[SAMPLE_DELAY-1];
                    r_dly_q <= r_line_q[SAMPLE_DELAY-1];
                end
            end
        end
    endgenerate

    // ---------------- magnitude squared ----------------
    logic [SMP_W-1:0] abs_i, abs_q;
    logic [SQ_W-1:0]  r_sq_i, r_sq_q;

    assign abs_i = r_cur_i[SMP_W-1] ? SMP_W'(~r_cur_i + 1'b1) : r_cur_i;
    assign abs_q = r_cur_q[SMP_W-1] ? SMP_W'(~r_cur_q + 1'b1) : r_cur_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sq_i <= {{(SQ_W-SMP_W){1'b0}}, abs_i} * {{(SQ_W-SMP_W){1'b0}}, abs_i};
            r_sq_q <= {{(SQ_W-SMP_W){1'b0}}, abs_q} * {{(SQ_W-SMP_W){1'b0}}, abs_q};
        end
    end

    // ---------------- iteration counter ----------------
    logic [ITER_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init || i_cmd.div_init) begin
            r_cnt <= '0;
        end else if (i_cmd.root_step || i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_stat.iter_last = (r_cnt == ITER_W'(iqepc_pkg::ITER_N - 1));

    // ---------------- square root, two radicand bits per step ----------------
    logic [SQ_W-1:0] r_x, r_res, r_bit;
    logic [SQ_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_x   <= r_sq_i + r_sq_q;
            r_res <= '0;
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (i_cmd.root_step) begin
            if (r_x >= trial) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // ---------------- peak hold ----------------
    logic [AMP_W-1:0] r_hist [0:HOLD_DEPTH-1];
    logic [AMP_W-1:0] r_hmax;
    logic [AMP_W-1:0] r_amp;
    logic [AMP_W-1:0] r_peak;
    logic [IDX_W-1:0] scan_idx;
    logic             scan_on;
    logic [SMP_W-1:0] env;
    logic [AMP_W-1:0] env_x, floor_x, target_x, excess;
    logic [AMP_W-1:0] peak_raw;

    // history is scanned one entry per root step, while it is still unchanged
    assign scan_idx = r_cnt[IDX_W-1:0];
    assign scan_on  = ({1'b0, r_cnt} < (ITER_W+1)'(HOLD_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_hmax <= '0;
        end else if (i_cmd.root_step && scan_on) begin
            if (r_hist[scan_idx] > r_hmax) begin
                r_hmax <= r_hist[scan_idx];
            end
        end
    end

    assign env      = r_res[SMP_W-1:0];
    assign env_x    = {{(AMP_W-SMP_W){1'b0}}, env};
    assign floor_x  = {{(AMP_W-LVL_W){1'b0}}, r_floor};
    assign target_x = {{(AMP_W-LVL_W){1'b0}}, r_target};
    assign excess   = env_x - target_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.amp) begin
            if (!r_clip_mode) begin
                r_amp <= (env_x > floor_x) ? env_x : floor_x;
            end else begin
                r_amp <= (env_x > target_x) ? ({excess[AMP_W-2:0], 1'b0} + target_x)
                                            : target_x;
            end
        end
    end

    assign peak_raw = (r_amp > r_hmax) ? r_amp : r_hmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HOLD_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_cmd.peak) begin
            r_hist[0] <= r_amp;
            for (int k = 1; k < HOLD_DEPTH; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.peak) begin
            // zero peak divides by one
            r_peak <= (peak_raw == '0) ? AMP_W'(1) : peak_raw;
        end
    end

    // ---------------- gain multiply ----------------
    logic [SMP_W-1:0]  dabs_i, dabs_q;
    logic [PROD_W-1:0] dabs_i_x, dabs_q_x, tgt_x;
    logic [PROD_W-1:0] r_prod_i, r_prod_q;
    logic              r_neg_i, r_neg_q;

    assign dabs_i   = r_dly_i[SMP_W-1] ? SMP_W'(~r_dly_i + 1'b1) : r_dly_i;
    assign dabs_q   = r_dly_q[SMP_W-1] ? SMP_W'(~r_dly_q + 1'b1) : r_dly_q;
    assign dabs_i_x = {{(PROD_W-SMP_W){1'b0}}, dabs_i};
    assign dabs_q_x = {{(PROD_W-SMP_W){1'b0}}, dabs_q};
    assign tgt_x    = {{(PROD_W-LVL_W){1'b0}}, r_target};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_i <= dabs_i_x * tgt_x;
            r_prod_q <= dabs_q_x * tgt_x;
            r_neg_i  <= r_dly_i[SMP_W-1];
            r_neg_q  <= r_dly_q[SMP_W-1];
        end
    end

    // ---------------- restoring divider, two lanes ----------------
    // quotients of 2^16 or more saturate anyway, so only 16 quotient bits are formed
    logic [AMP_W-1:0]        r_rem_i, r_rem_q;
    logic [SMP_W-1:0]        r_dvd_i, r_dvd_q;
    logic [SMP_W-1:0]        r_quo_i, r_quo_q;
    logic                    r_ovf_i, r_ovf_q;
    logic [AMP_W:0]          shf_i, shf_q;
    logic [AMP_W:0]          dif_i, dif_q;
    logic [AMP_W+SMP_W-1:0]  peak_hi;

    assign peak_hi = {r_peak, {SMP_W{1'b0}}};
    assign shf_i   = {r_rem_i, r_dvd_i[SMP_W-1]};
    assign shf_q   = {r_rem_q, r_dvd_q[SMP_W-1]};
    assign dif_i   = shf_i - {1'b0, r_peak};
    assign dif_q   = shf_q - {1'b0, r_peak};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_ovf_i <= ({{(AMP_W+SMP_W-PROD_W){1'b0}}, r_prod_i} >= peak_hi);
            r_ovf_q <= ({{(AMP_W+SMP_W-PROD_W){1'b0}}, r_prod_q} >= peak_hi);
            r_rem_i <= {{(AMP_W-HI_W){1'b0}}, r_prod_i[PROD_W-1:SMP_W]};
            r_rem_q <= {{(AMP_W-HI_W){1'b0}}, r_prod_q[PROD_W-1:SMP_W]};
            r_dvd_i <= r_prod_i[SMP_W-1:0];
            r_dvd_q <= r_prod_q[SMP_W-1:0];
            r_quo_i <= '0;
            r_quo_q <= '0;
        end else if (i_cmd.div_step) begin
            if (shf_i >= {1'b0, r_peak}) begin
                r_rem_i <= dif_i[AMP_W-1:0];
            end else begin
                r_rem_i <= shf_i[AMP_W-1:0];
            end
            if (shf_q >= {1'b0, r_peak}) begin
                r_rem_q <= dif_q[AMP_W-1:0];
            end else begin
                r_rem_q <= shf_q[AMP_W-1:0];
            end
            r_dvd_i <= r_dvd_i << 1;
            r_dvd_q <= r_dvd_q << 1;
            r_quo_i <= {r_quo_i[SMP_W-2:0], (shf_i >= {1'b0, r_peak})};
            r_quo_q <= {r_quo_q[SMP_W-2:0], (shf_q >= {1'b0, r_peak})};
        end
    end

    // ---------------- sign, saturation and output register ----------------
    function automatic logic signed [SMP_W-1:0] sat16(
        input logic             ovf,
        input logic             neg,
        input logic [SMP_W-1:0] quo
    );
        logic signed [SMP_W-1:0] res;
        if (ovf) begin
            res = neg ? iqepc_pkg::SAT_MIN : iqepc_pkg::SAT_MAX;
        end else if (!neg) begin
            res = (quo > iqepc_pkg::POS_LIM) ? iqepc_pkg::SAT_MAX : signed'(quo);
        end else begin
            res = (quo > iqepc_pkg::NEG_LIM) ? iqepc_pkg::SAT_MIN
                                             : signed'(SMP_W'(~quo + 1'b1));
        end
        return res;
    endfunction

    logic                 r_out_valid;
    iqepc_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.out_i <= sat16(r_ovf_i, r_neg_i, r_quo_i);
            r_out.out_q <= sat16(r_ovf_q, r_neg_q, r_quo_q);
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

`default_nettype wire

[sv/iq_envelope_peak_clipper.sv]
// Envelope clipper with peak hold for I/Q samples. Each accepted sample pair
// occupies the block until it has passed every step, so a new sample is
// accepted only after that: a 16-step bit-pair square root of I*I+Q*Q and a
// 16-step restoring divide (both lanes at once) dominate, run by one
// sequencer, plus eight further steps including the accepting one.
// The result appears in an output register, so the next sample is accepted
// while a finished result still waits; only if the previous result is still
// unread when the next one is done does the block stall. The outputs are the
// samples from SAMPLE_DELAY items earlier scaled by target_level over the held
// peak, saturated to 16 bits. Configuration is written through a plain write
// port and must only change while the block is idle.
// ----------------------------------------------------------------------------
// iq_envelope_peak_clipper
// top level: sequencer plus envelope, peak hold and scaling datapath
// ----------------------------------------------------------------------------
`default_nettype none

module iq_envelope_peak_clipper #(
    parameter int HOLD_DEPTH   = iqepc_pkg::HOLD_DEPTH_DEF,
    parameter int SAMPLE_DELAY = iqepc_pkg::SAMPLE_DELAY_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [iqepc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [iqepc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire iqepc_pkg::t_in_item                i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output iqepc_pkg::t_out_item                    o_out_data
);

    iqepc_pkg::t_dp_cmd  cmd;
    iqepc_pkg::t_dp_stat stat;

    iqepc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    iqepc_dp #(
        .HOLD_DEPTH   (HOLD_DEPTH),
        .SAMPLE_DELAY (SAMPLE_DELAY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[sv/iqepc_checker.sv]
// ----------------------------------------------------------------------------
// iqepc_checker
// port-level checks of the envelope clipper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "iq_envelope_peak_clipper_assert.svh"

module iqepc_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire iqepc_pkg::t_out_item o_out_data
);

    // a stalled result transaction stays offered
    `IQEPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `IQEPC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data), "result changed while stalled")

    // one sample at a time: ready drops right after an input transaction
    `IQEPC_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken while busy")

    // a fresh result means the sequencer is back waiting for input
    `IQEPC_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, $rose(o_out_valid), o_in_ready, "result without return to idle")

endmodule

bind iq_envelope_peak_clipper iqepc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[dv/iq_envelope_peak_clipper_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iq_envelope_peak_clipper_test
// drives I/Q samples through the envelope clipper under random valid/ready
// gaps and several register settings, predicts each clipped sample in a
// scoreboard and compares it field by field with the block's output
// ----------------------------------------------------------------------------

module iq_envelope_peak_clipper_test;

    localparam int SMP_W      = iqepc_pkg::SMP_W;
    localparam int CFG_IDX_W  = iqepc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = iqepc_pkg::CFG_DATA_W;
    localparam int HOLD_N     = iqepc_pkg::HOLD_DEPTH_DEF;
    localparam int DELAY_N    = iqepc_pkg::SAMPLE_DELAY_DEF;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 200;

    class clip_result_board;
        int clip_mode;
        int floor_lvl;
        int target_lvl;
        int level_hist[HOLD_N];
        int delay_i[DELAY_N];
        int delay_q[DELAY_N];
        iqepc_pkg::t_out_item pending_out[$];
        int errors;
        int n_samples;
        int n_results;

        function new();
            clip_mode  = 0;
            floor_lvl  = int'(iqepc_pkg::FLOOR_RST);
            target_lvl = int'(iqepc_pkg::TARGET_RST);
            foreach (level_hist[k]) level_hist[k] = 0;
            foreach (delay_i[k]) begin
                delay_i[k] = 0;
                delay_q[k] = 0;
            end
            errors    = 0;
            n_samples = 0;
            n_results = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                iqepc_pkg::CFG_CLIP_MODE:    clip_mode  = int'(data[0]);
                iqepc_pkg::CFG_FLOOR_LEVEL:  floor_lvl  = int'(data);
                iqepc_pkg::CFG_TARGET_LEVEL: target_lvl = int'(data);
                default: ;
            endcase
        endfunction

        function int root_floor(longint val);
            longint root;
            longint trial;
            root = 0;
            for (int b = 15; b >= 0; b--) begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= val) root = trial;
            end
            return int'(root);
        endfunction

        function logic [SMP_W-1:0] scale_clip(int smp, int peak);
            longint v;
            v = (longint'(smp) * longint'(target_lvl)) / longint'(peak);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[SMP_W-1:0];
        endfunction

        function iqepc_pkg::t_out_item predict_output(iqepc_pkg::t_in_item s);
            int si;
            int sq;
            int env;
            int amp;
            int peak;
            iqepc_pkg::t_out_item res;
            si  = s.in_i;
            sq  = s.in_q;
            env = root_floor(longint'(si) * si + longint'(sq) * sq);
            if (clip_mode == 0) begin
                amp = (env > floor_lvl) ? env : floor_lvl;
            end else begin
                amp = (env > target_lvl) ? (env - target_lvl) * 2 + target_lvl : target_lvl;
            end
            peak = amp;
            foreach (level_hist[k]) if (level_hist[k] > peak) peak = level_hist[k];
            for (int k = HOLD_N - 1; k > 0; k--) level_hist[k] = level_hist[k-1];
            level_hist[0] = amp & 32'h1FFFF;
            // an all-zero hold window divides by one
            if (peak == 0) peak = 1;
            res.out_i = scale_clip(delay_i[DELAY_N-1], peak);
            res.out_q = scale_clip(delay_q[DELAY_N-1], peak);
            for (int k = DELAY_N - 1; k > 0; k--) begin
                delay_i[k] = delay_i[k-1];
                delay_q[k] = delay_q[k-1];
            end
            delay_i[0] = si;
            delay_q[0] = sq;
            return res;
        endfunction

        function void note_sample(iqepc_pkg::t_in_item s);
            pending_out.push_back(predict_output(s));
            n_samples++;
        endfunction

        function void check_result(iqepc_pkg::t_out_item got);
            iqepc_pkg::t_out_item want;
            n_results++;
            if (pending_out.size() == 0) begin
                $error("unexpected output transaction: out_i %0d out_q %0d",
                       got.out_i, got.out_q);
                errors++;
                return;
            end
            want = pending_out.pop_front();
            if (got.out_i !== want.out_i) begin
                $error("out_i mismatch: expected %0d, got %0d", want.out_i, got.out_i);
                errors++;
            end
            if (got.out_q !== want.out_q) begin
                $error("out_q mismatch: expected %0d, got %0d", want.out_q, got.out_q);
                errors++;
            end
        endfunction

        function int pending();
            return pending_out.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    iqepc_pkg::t_in_item   i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    iqepc_pkg::t_out_item  o_out_data;

    clip_result_board board = new();
    bit idle_en = 1'b0;
    int rx_hold_req = 0;
    int n_settings = 0;
    int quiet_cycles = 0;

    iq_envelope_peak_clipper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // no transaction on either side for too long means the block hung
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we
                || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("iq_envelope_peak_clipper_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output side: random ready gaps, one long hold-off on request
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                gap = idle_en ? $urandom_range(0, 6) : 0;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_result(o_out_data);
        end
    end

    task automatic send_sample(iqepc_pkg::t_in_item s);
        int gap;
        gap = idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(s);
    endtask

    task automatic send_pair(int si, int sq);
        iqepc_pkg::t_in_item s;
        s.in_i = si[SMP_W-1:0];
        s.in_q = sq[SMP_W-1:0];
        send_sample(s);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic apply_setting(int mode_data, int floor_v, int target_v);
        write_reg(iqepc_pkg::CFG_CLIP_MODE, mode_data[CFG_DATA_W-1:0]);
        write_reg(iqepc_pkg::CFG_FLOOR_LEVEL, floor_v[CFG_DATA_W-1:0]);
        write_reg(iqepc_pkg::CFG_TARGET_LEVEL, target_v[CFG_DATA_W-1:0]);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_NO_REG, CFG_DATA_W'($urandom));
        n_settings++;
    endtask

    function automatic int rand_level();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: return 0;
            1: return 1;
            2: return 4096;
            3: return 5792;
            4: return 6553;
            5: return 23166;
            6: return 32767;
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    function automatic logic [SMP_W-1:0] rand_component(int kind);
        int corners[6] = '{-32768, -32767, -1, 0, 1, 32767};
        case (kind)
            0: return SMP_W'($urandom);
            1: return SMP_W'($urandom_range(0, 128)) - 16'd64;
            2: return $signed(SMP_W'($urandom)) >>> $urandom_range(0, 15);
            default: return corners[$urandom_range(0, 5)][SMP_W-1:0];
        endcase
    endfunction

    function automatic iqepc_pkg::t_in_item rand_sample();
        int pick;
        int kind;
        iqepc_pkg::t_in_item s;
        pick = $urandom_range(0, 99);
        kind = (pick < 40) ? 0 : (pick < 60) ? 1 : (pick < 88) ? 2 : 3;
        s.in_i = rand_component(kind);
        s.in_q = rand_component(kind);
        return s;
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: start-up zeros, corners of the sample range
        send_pair(32767, 32767);
        send_pair(-32768, -32768);
        send_pair(-32768, 0);
        send_pair(0, -32768);
        send_pair(32767, -32768);
        send_pair(0, 0);
        send_pair(1, 0);
        send_pair(-1, -1);
        send_pair(100, -100);
        wait_for_results();

        // overshoot mode from a wide value, plus a write to the unused index
        write_reg(iqepc_pkg::CFG_CLIP_MODE, 15'h5555);
        write_reg(iqepc_pkg::CFG_FLOOR_LEVEL, 15'd1);
        write_reg(iqepc_pkg::CFG_TARGET_LEVEL, 15'd4096);
        write_reg(CFG_NO_REG, 15'h7FFF);
        n_settings++;
        send_pair(5000, 3000);
        send_pair(-32768, 32767);
        send_pair(4096, 0);
        send_pair(-4095, 1);
        send_pair(20000, -20000);
        send_pair(0, 0);
        send_pair(12, -7);
        wait_for_results();

        // zero floor in clip mode: a quiet window leaves the peak at zero
        write_reg(iqepc_pkg::CFG_CLIP_MODE, 15'h7FFE);
        write_reg(iqepc_pkg::CFG_FLOOR_LEVEL, 15'd0);
        write_reg(iqepc_pkg::CFG_TARGET_LEVEL, 15'd32767);
        n_settings++;
        repeat (6) send_pair(0, 0);
        send_pair(1, 0);
        send_pair(0, -1);
        wait_for_results();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: apply_setting(2, 32767, 1);
                1: apply_setting(1, 1, 32767);
                2: apply_setting(1, 0, 0);
                3: apply_setting(0, 1, 32767);
                default: apply_setting($urandom_range(0, 32767), rand_level(), rand_level());
            endcase
            idle_en = (p % 3) != 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // output held off while samples keep coming
                if (p == 2 && k == 60) rx_hold_req = LONG_HOLD;
                if (p == 5 && k == 100) wait_for_results();
                send_sample(rand_sample());
            end
            wait_for_results();
        end

        repeat (50) @(posedge i_clk);
        $display("summary: %0d samples in, %0d results checked, %0d register settings",
                 board.n_samples, board.n_results, n_settings);
        $display("summary: clip and overshoot modes, zero and full-scale levels, long stall");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("iq_envelope_peak_clipper_test: clean");
        end else begin
            $display("iq_envelope_peak_clipper_test: errors");
        end
        $finish;
    end

endmodule
